// ----- rtl/gtn_pkg.sv -----
// Shared types and constants for the grid torus neighbour enumerator.
// No dependencies; every other file imports this package.
package gtn_pkg;

    localparam int AXIS_SLOTS  = 4;
    localparam int AX_BITS     = $clog2(AXIS_SLOTS);
    localparam int SLOTS       = 2 * AXIS_SLOTS;
    localparam int SLOT_BITS   = $clog2(SLOTS);
    localparam int STEP_BITS   = $clog2(2 * AXIS_SLOTS - 1);
    localparam int POS_BITS    = 10;
    localparam int SIZE_BITS   = 11;
    localparam int CNT_BITS    = 3;
    localparam int ID_BITS     = 40;
    localparam int STRIDE_BITS = 31;
    localparam int MUL_BITS    = STRIDE_BITS + SIZE_BITS;
    localparam int PROD_BITS   = STRIDE_BITS + POS_BITS;

    localparam logic [SIZE_BITS-1:0] SIZE_CAP = 11'd1024;

    // register indexes on the configuration port
    localparam logic [CNT_BITS-1:0] REG_NUM_AXES    = 3'd0;
    localparam logic [CNT_BITS-1:0] REG_CYCLIC_AXES = 3'd1;
    localparam logic [CNT_BITS-1:0] REG_SIZE_AXIS0  = 3'd2;
    localparam logic [CNT_BITS-1:0] REG_SIZE_AXIS1  = 3'd3;
    localparam logic [CNT_BITS-1:0] REG_SIZE_AXIS2  = 3'd4;
    localparam logic [CNT_BITS-1:0] REG_SIZE_AXIS3  = 3'd5;

    typedef struct packed {
        logic [POS_BITS-1:0] pos_axis0;
        logic [POS_BITS-1:0] pos_axis1;
        logic [POS_BITS-1:0] pos_axis2;
        logic [POS_BITS-1:0] pos_axis3;
    } gtn_in_t;

    typedef struct packed {
        logic [ID_BITS-1:0] point_id;
        logic [ID_BITS-1:0] neighbour_id;
        logic [1:0]         axis;
        logic               upper_side;
        logic               wrapped;
        logic               bad_position;
        logic               last;
    } gtn_out_t;

    // geometry derived from the configuration registers
    typedef struct packed {
        logic [AXIS_SLOTS-1:0]                  in_use;
        logic [AXIS_SLOTS-1:0]                  cyc;
        logic [AXIS_SLOTS-1:0][SIZE_BITS-1:0]   eff_size;
        logic [AXIS_SLOTS-1:0][STRIDE_BITS-1:0] stride;
        logic [AXIS_SLOTS-1:0][ID_BITS-1:0]     span;
        logic                                   busy;
    } gtn_geom_t;

    typedef struct packed {
        logic [AXIS_SLOTS-1:0][ID_BITS-1:0] prod;
        logic [AXIS_SLOTS-1:0]              lo;
        logic [AXIS_SLOTS-1:0]              hi;
        logic                               bad;
    } gtn_stage_a_t;

    typedef struct packed {
        logic [ID_BITS-1:0]    sum_lo;
        logic [ID_BITS-1:0]    sum_hi;
        logic [AXIS_SLOTS-1:0] lo;
        logic [AXIS_SLOTS-1:0] hi;
        logic                  bad;
    } gtn_stage_b_t;

    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [AXIS_SLOTS-1:0] lo;
        logic [AXIS_SLOTS-1:0] hi;
        logic                  bad;
    } gtn_stage_c_t;

    // one point with all of its candidate neighbour slots
    typedef struct packed {
        logic [ID_BITS-1:0]            pid;
        logic [SLOTS-1:0][ID_BITS-1:0] nid;
        logic [SLOTS-1:0]              wrap;
        logic [SLOTS-1:0]              mask;
        logic                          bad;
    } gtn_item_t;

endpackage

// ----- rtl/gtn_if.sv -----
// Stream interfaces for the point input channel and the result channel.
// Depends on gtn_pkg for the payload structs.
interface gtn_in_if import gtn_pkg::*; ();
    logic    valid;
    logic    ready;
    gtn_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gtn_out_if import gtn_pkg::*; ();
    logic     valid;
    logic     ready;
    gtn_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/gtn_stride_unit.sv -----
// Configuration registers and the stride/span sequencer.
// Depends on gtn_pkg. One multiply per cycle, 2*AXIS_SLOTS-1 steps after a write.
module gtn_stride_unit import gtn_pkg::*; #(
    parameter int MAX_AXES = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CNT_BITS-1:0]  cfg_index,
    input  logic [SIZE_BITS-1:0] cfg_data,
    output gtn_geom_t            geom
);

    localparam int AXIS_CAP = (MAX_AXES < AXIS_SLOTS) ? MAX_AXES : AXIS_SLOTS;
    localparam logic [CNT_BITS-1:0] CAP_N = CNT_BITS'(AXIS_CAP);
    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(2 * AXIS_SLOTS - 2);
    localparam logic [STEP_BITS-1:0] STEP_SPAN = STEP_BITS'(AXIS_SLOTS - 1);

    logic [CNT_BITS-1:0]                    num_axes_reg;
    logic [CNT_BITS-1:0]                    cyclic_axes_reg;
    logic [AXIS_SLOTS-1:0][SIZE_BITS-1:0]   size_reg;
    logic [AXIS_SLOTS-1:0][STRIDE_BITS-1:0] stride_reg, stride_next;
    logic [AXIS_SLOTS-1:0][ID_BITS-1:0]     span_reg, span_next;
    logic                                   busy_reg, busy_next;
    logic [STEP_BITS-1:0]                   step_reg, step_next;

    logic [CNT_BITS-1:0]                  nax;
    logic [AXIS_SLOTS-1:0]                in_use;
    logic [AXIS_SLOTS-1:0]                cyc;
    logic [AXIS_SLOTS-1:0][SIZE_BITS-1:0] eff;
    logic                                 span_phase;
    logic [STEP_BITS-1:0]                 idx_wide;
    logic [AX_BITS-1:0]                   idx;
    logic [STRIDE_BITS-1:0]               op_a;
    logic [SIZE_BITS-1:0]                 op_b;
    logic [MUL_BITS-1:0]                  mul;

    always_comb
    begin
        nax = (num_axes_reg == '0) ? CNT_BITS'(1) : num_axes_reg;
        if (nax > CAP_N)
        begin
            nax = CAP_N;
        end
        for (int d = 0; d < AXIS_SLOTS; d++)
        begin
            in_use[d] = CNT_BITS'(d) < nax;
            cyc[d]    = CNT_BITS'(d) < cyclic_axes_reg;
            eff[d]    = (size_reg[d] > SIZE_CAP) ? SIZE_CAP : size_reg[d];
        end
    end

    // stride phase walks from the last axis down, span phase walks up
    always_comb
    begin
        stride_next = stride_reg;
        span_next   = span_reg;
        step_next   = step_reg;
        busy_next   = busy_reg;
        span_phase  = step_reg >= STEP_SPAN;
        if (span_phase)
        begin
            idx_wide = step_reg - STEP_SPAN;
        end
        else
        begin
            idx_wide = STEP_SPAN - step_reg;
        end
        idx  = idx_wide[AX_BITS-1:0];
        op_a = stride_reg[idx];
        op_b = span_phase ? (eff[idx] - SIZE_BITS'(1)) : eff[idx];
        mul  = MUL_BITS'(op_a) * MUL_BITS'(op_b);
        if (cfg_we)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            if (span_phase)
            begin
                span_next[idx] = ID_BITS'(mul);
            end
            else
            begin
                stride_next[idx - AX_BITS'(1)] = in_use[idx] ? STRIDE_BITS'(mul)
                                                             : STRIDE_BITS'(1);
            end
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + STEP_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_axes_reg    <= CNT_BITS'(1);
            cyclic_axes_reg <= '0;
            for (int d = 0; d < AXIS_SLOTS; d++)
            begin
                size_reg[d]   <= SIZE_BITS'(1);
                stride_reg[d] <= STRIDE_BITS'(1);
                span_reg[d]   <= '0;
            end
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_NUM_AXES:    num_axes_reg    <= cfg_data[CNT_BITS-1:0];
                    REG_CYCLIC_AXES: cyclic_axes_reg <= cfg_data[CNT_BITS-1:0];
                    REG_SIZE_AXIS0:  size_reg[0]     <= cfg_data;
                    REG_SIZE_AXIS1:  size_reg[1]     <= cfg_data;
                    REG_SIZE_AXIS2:  size_reg[2]     <= cfg_data;
                    REG_SIZE_AXIS3:  size_reg[3]     <= cfg_data;
                    default:         ;
                endcase
            end
            stride_reg <= stride_next;
            span_reg   <= span_next;
            busy_reg   <= busy_next;
            step_reg   <= step_next;
        end
    end

    assign geom.in_use   = in_use;
    assign geom.cyc      = cyc;
    assign geom.eff_size = eff;
    assign geom.stride   = stride_reg;
    assign geom.span     = span_reg;
    assign geom.busy     = busy_reg;

endmodule

// ----- rtl/gtn_point_pipe.sv -----
// Three-stage point pipeline: range check and products, pair sums, linear id.
// Depends on gtn_pkg; neighbour ids are formed on the way out of the last stage.
module gtn_point_pipe import gtn_pkg::*; #(
    parameter int COORD_BITS = 10
) (
    input  logic      clk,
    input  logic      rst_n,
    input  gtn_geom_t geom,
    input  logic      in_valid,
    input  gtn_in_t   in_data,
    output logic      in_ready,
    output logic      item_valid,
    output gtn_item_t item,
    input  logic      item_ready
);

    localparam int CB = (COORD_BITS < POS_BITS) ? COORD_BITS : POS_BITS;
    localparam logic [POS_BITS-1:0] POS_MASK = POS_BITS'((1 << CB) - 1);

    logic         a_v_reg, b_v_reg, c_v_reg;
    gtn_stage_a_t a_reg, a_next;
    gtn_stage_b_t b_reg, b_next;
    gtn_stage_c_t c_reg, c_next;
    logic         a_ready, b_ready, c_ready;

    logic [AXIS_SLOTS-1:0][POS_BITS-1:0] pos_raw;
    logic [AXIS_SLOTS-1:0][POS_BITS-1:0] pos;
    logic [PROD_BITS-1:0]                prod_full;
    logic [SIZE_BITS-1:0]                pos_up;

    assign pos_raw[0] = in_data.pos_axis0;
    assign pos_raw[1] = in_data.pos_axis1;
    assign pos_raw[2] = in_data.pos_axis2;
    assign pos_raw[3] = in_data.pos_axis3;

    assign c_ready  = !c_v_reg || item_ready;
    assign b_ready  = !b_v_reg || c_ready;
    assign a_ready  = !a_v_reg || b_ready;
    assign in_ready = a_ready && !geom.busy;

    always_comb
    begin
        a_next     = '0;
        prod_full  = '0;
        pos_up     = '0;
        for (int d = 0; d < AXIS_SLOTS; d++)
        begin
            pos[d]        = pos_raw[d] & POS_MASK;
            pos_up        = {1'b0, pos[d]} + SIZE_BITS'(1);
            prod_full     = PROD_BITS'(pos[d]) * PROD_BITS'(geom.stride[d]);
            a_next.prod[d] = geom.in_use[d] ? prod_full[ID_BITS-1:0] : '0;
            a_next.lo[d]  = pos[d] == '0;
            a_next.hi[d]  = pos_up >= geom.eff_size[d];
            if (geom.in_use[d] && ({1'b0, pos[d]} >= geom.eff_size[d]))
            begin
                a_next.bad = 1'b1;
            end
        end
    end

    always_comb
    begin
        b_next.sum_lo = '0;
        b_next.sum_hi = '0;
        for (int d = 0; d < AXIS_SLOTS; d++)
        begin
            if (d < AXIS_SLOTS / 2)
            begin
                b_next.sum_lo = b_next.sum_lo + a_reg.prod[d];
            end
            else
            begin
                b_next.sum_hi = b_next.sum_hi + a_reg.prod[d];
            end
        end
        b_next.lo  = a_reg.lo;
        b_next.hi  = a_reg.hi;
        b_next.bad = a_reg.bad;
    end

    always_comb
    begin
        c_next.id  = b_reg.sum_lo + b_reg.sum_hi;
        c_next.lo  = b_reg.lo;
        c_next.hi  = b_reg.hi;
        c_next.bad = b_reg.bad;
    end

    // slot 2d is the lower neighbour on axis d, slot 2d+1 the upper one
    always_comb
    begin
        item.pid = c_reg.id;
        item.bad = c_reg.bad;
        for (int d = 0; d < AXIS_SLOTS; d++)
        begin
            item.nid[2*d]    = c_reg.lo[d] ? (c_reg.id + geom.span[d])
                                           : (c_reg.id - ID_BITS'(geom.stride[d]));
            item.nid[2*d+1]  = c_reg.hi[d] ? (c_reg.id - geom.span[d])
                                           : (c_reg.id + ID_BITS'(geom.stride[d]));
            item.wrap[2*d]   = c_reg.lo[d];
            item.wrap[2*d+1] = c_reg.hi[d];
            item.mask[2*d]   = geom.in_use[d] && (!c_reg.lo[d] || geom.cyc[d]);
            item.mask[2*d+1] = geom.in_use[d] && (!c_reg.hi[d] || geom.cyc[d]);
        end
    end

    assign item_valid = c_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_v_reg <= in_valid && !geom.busy;
            end
            if (b_ready)
            begin
                b_v_reg <= a_v_reg;
            end
            if (c_ready)
            begin
                c_v_reg <= b_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_reg <= a_next;
        end
        if (b_ready && a_v_reg)
        begin
            b_reg <= b_next;
        end
        if (c_ready && b_v_reg)
        begin
            c_reg <= c_next;
        end
    end

endmodule

// ----- rtl/gtn_emitter.sv -----
// Result sequencer: holds one point and walks its neighbour slots, one beat a cycle while out_ready is high.
// Depends on gtn_pkg.
module gtn_emitter import gtn_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  gtn_item_t item,
    output logic      item_ready,
    output logic      out_valid,
    output gtn_out_t  out_data,
    input  logic      out_ready
);

    logic                          v_reg;
    logic                          bad_reg;
    logic [SLOTS-1:0]              mask_reg;
    logic [ID_BITS-1:0]            pid_reg;
    logic [SLOTS-1:0][ID_BITS-1:0] nid_reg;
    logic [SLOTS-1:0]              wrap_reg;

    logic [SLOTS-1:0]     sel;
    logic [SLOTS-1:0]     rest;
    logic [SLOT_BITS-1:0] slot;
    logic                 last_beat;
    logic                 keep;

    always_comb
    begin
        sel  = mask_reg & (~mask_reg + SLOTS'(1));
        rest = mask_reg & ~sel;
        slot = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (sel[s])
            begin
                slot = slot | SLOT_BITS'(s);
            end
        end
        last_beat = bad_reg || (rest == '0);
    end

    assign item_ready = !v_reg || (out_ready && last_beat);
    assign keep       = item.bad || (item.mask != '0);
    assign out_valid  = v_reg;

    always_comb
    begin
        out_data = '0;
        if (bad_reg)
        begin
            out_data.bad_position = 1'b1;
            out_data.last         = 1'b1;
        end
        else
        begin
            out_data.point_id     = pid_reg;
            out_data.neighbour_id = nid_reg[slot];
            out_data.axis         = slot[SLOT_BITS-1:1];
            out_data.upper_side   = slot[0];
            out_data.wrapped      = wrap_reg[slot];
            out_data.last         = last_beat;
        end
    end

    // points with no neighbours are dropped here without a beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= 1'b0;
            mask_reg <= '0;
            bad_reg  <= 1'b0;
        end
        else if (item_ready)
        begin
            v_reg    <= item_valid && keep;
            mask_reg <= item.mask;
            bad_reg  <= item.bad;
        end
        else if (out_ready)
        begin
            mask_reg <= rest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            pid_reg  <= item.pid;
            nid_reg  <= item.nid;
            wrap_reg <= item.wrap;
        end
    end

endmodule

// ----- rtl/grid_torus_neighbour_enumerator_core.sv -----
// Grid neighbour enumerator: turns one point into its row-major id and neighbour ids.
// Depends on gtn_pkg, gtn_if, gtn_stride_unit, gtn_point_pipe and gtn_emitter.
//
// Usage:
//   points  - valid/ready channel, one beat per grid point (pos_axis0..3).
//   results - valid/ready channel, one beat per neighbour, lower before upper,
//             axis 0 first; last marks the final beat of a point. A point with
//             a coordinate out of range gives one beat with bad_position set.
//             A point with no neighbours gives no beat at all.
//   cfg_*   - write port, register i at index i; write only while idle.
// The first beat of a point reaches results through the three pipeline stages and
//   then the result register.
// Throughput: one result beat per cycle while results.ready is high; a point with
//   k neighbours holds the result sequencer for its k beats (at most 8 with four
//   axes). Points are taken back to back while results drain.
// After each config write the stride sequencer runs (one multiply a cycle) and
//   points.ready stays low meanwhile.
// Reset: one axis of size 1, no cyclic axes, all strides 1, pipeline empty.
// A stalled results channel holds its beat and backs up the pipeline in
//   order; nothing is dropped or repeated.
module grid_torus_neighbour_enumerator_core import gtn_pkg::*; #(
    parameter int MAX_AXES   = 4,
    parameter int COORD_BITS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    gtn_in_if.sink               points,
    gtn_out_if.source            results,
    input  logic                 cfg_we,
    input  logic [CNT_BITS-1:0]  cfg_index,
    input  logic [SIZE_BITS-1:0] cfg_data
);

    gtn_geom_t geom;
    logic      item_valid;
    logic      item_ready;
    gtn_item_t item;

    gtn_stride_unit #(
        .MAX_AXES (MAX_AXES)
    ) u_stride (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    gtn_point_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom),
        .in_valid   (points.valid),
        .in_data    (points.data),
        .in_ready   (points.ready),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready)
    );

    gtn_emitter u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .out_valid  (results.valid),
        .out_data   (results.data),
        .out_ready  (results.ready)
    );

endmodule

// ----- rtl/gtn_checker.sv -----
// Port-level checks for the grid neighbour enumerator, bound to the top level.
// Depends on gtn_pkg and grid_torus_neighbour_enumerator_core.
module gtn_checker import gtn_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               pt_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic [ID_BITS-1:0] res_pid,
    input logic [ID_BITS-1:0] res_nid,
    input logic               res_wrapped,
    input logic               res_bad,
    input logic               res_last,
    input logic               cfg_we
);

    // strides are being rebuilt right after a write
    a_cfg_blocks_points: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !pt_ready)
        else $error("points accepted while strides are rebuilt");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_pid) && $stable(res_nid)
            && $stable(res_last))
        else $error("stalled result beat changed");

    a_bad_beat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_bad |-> res_last && !res_wrapped && res_pid == '0
            && res_nid == '0)
        else $error("bad position beat malformed");

    // beats of one point follow without gaps and share the point id
    a_point_burst: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |=> res_valid && $stable(res_pid))
        else $error("neighbour burst broken");

endmodule

bind grid_torus_neighbour_enumerator_core gtn_checker u_gtn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pt_ready    (points.ready),
    .res_valid   (results.valid),
    .res_ready   (results.ready),
    .res_pid     (results.data.point_id),
    .res_nid     (results.data.neighbour_id),
    .res_wrapped (results.data.wrapped),
    .res_bad     (results.data.bad_position),
    .res_last    (results.data.last),
    .cfg_we      (cfg_we)
);
